// File: sv/cau_pkg.sv
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int PART_W = 16;
    localparam int PROD_W = 2 * PART_W + 1;     // sum of two 16x16 products
    localparam int DEN_W  = 2 * PART_W + 1;     // br^2 + bi^2, unsigned
    localparam int NUM_W  = PROD_W + 15;        // numerator scaled by up to 2^15
    localparam int QUO_W  = NUM_W;              // quotient magnitude width
    localparam int NCELLS = QUO_W;              // one quotient bit per cell

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
    } cau_req_t;

    typedef struct packed {
        logic signed [15:0] res_real;
        logic signed [15:0] res_imag;
        logic               saturated;
        logic               div_by_zero;
    } cau_res_t;

    // Work carried from one cell to the next.
    typedef struct packed {
        logic                    valid;
        logic [1:0]              op;
        logic                    dz;
        logic signed [PROD_W-1:0] re_pre;   // add/sub/mul result before clip
        logic signed [PROD_W-1:0] im_pre;
        logic [DEN_W-1:0]        den;
        logic                    re_neg;
        logic                    im_neg;
        logic [NUM_W-1:0]        re_rem;    // remainder, reduced by the shifted divisor in each cell
        logic [NUM_W-1:0]        im_rem;
        logic [QUO_W-1:0]        re_quo;
        logic [QUO_W-1:0]        im_quo;
    } cau_work_t;

    // Saturate a wide signed value to 16 bits; flag when clipped.
    function automatic logic [16:0] clip16(input logic signed [NUM_W:0] v);
        logic [16:0] r;
        if (v > $signed((NUM_W+1)'(32767)))
            r = {1'b1, 16'sh7FFF};
        else if (v < -$signed((NUM_W+1)'(32768)))
            r = {1'b1, 16'sh8000};
        else
            r = {1'b0, v[15:0]};
        return r;
    endfunction

endpackage

// File: sv/complex_arith_unit_core.sv
// Top level of the complex arithmetic unit: operand stage, divider cell chain, output.
// Registers: operand stage, divider cells (NCELLS = 48, one quotient bit per divider cell), output.
// Throughput: one transfer per cycle while the output is not stalled; every operation flows through the same chain.
// The chain advances whenever the output register is empty or being drained.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// A stall on the output side holds every stage in place.
module complex_arith_unit_core
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cau_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cau_res_t out_data
);

    cau_work_t chain [NCELLS+1];
    logic      en;
    logic      out_valid_reg;
    cau_res_t  out_reg;
    cau_res_t  out_next;
    logic signed [NUM_W:0] re_w, im_w;
    logic [16:0] cre, cim;
    cau_work_t last;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid), .req(in_data), .dout(chain[0])
    );

    // Cells run from the top quotient bit down to bit zero.
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        cau_cell #(.BIT(NCELLS-1-i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .din(chain[i]), .dout(chain[i+1])
        );
    end

    assign last = chain[NCELLS];

    // Sign the quotients, then saturate whichever result applies.
    always_comb
    begin
        if (last.op == OP_DIV)
        begin
            re_w = last.re_neg ? -$signed({1'b0, last.re_quo}) : $signed({1'b0, last.re_quo});
            im_w = last.im_neg ? -$signed({1'b0, last.im_quo}) : $signed({1'b0, last.im_quo});
        end
        else
        begin
            re_w = (NUM_W+1)'(last.re_pre);
            im_w = (NUM_W+1)'(last.im_pre);
        end
        cre = clip16(re_w);
        cim = clip16(im_w);
        out_next.res_real = last.dz ? 16'sd0 : cre[15:0];
        out_next.res_imag = last.dz ? 16'sd0 : cim[15:0];
        out_next.saturated = !last.dz && (cre[16] || cim[16]);
        out_next.div_by_zero = last.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A stalled result must hold until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Divide-by-zero never comes with saturation.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_by_zero |-> !out_data.saturated)
        else $error("saturation flagged on zero divisor");

    // Input side is ready whenever the output is free.
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

// File: sv/cau_cell.sv
// One restoring-division cell: retires one quotient bit for both parts.
module cau_cell
    import cau_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cau_work_t din,
    output cau_work_t dout
);

    logic                         valid_reg;
    logic [$bits(cau_work_t)-2:0] payload_reg;
    cau_work_t work_next;
    logic [NUM_W+DEN_W-1:0] dsh;
    logic [NUM_W+DEN_W-1:0] re_ext;
    logic [NUM_W+DEN_W-1:0] im_ext;

    // Compare each remainder against the divisor shifted to this bit.
    always_comb
    begin
        work_next = din;
        dsh = {{NUM_W{1'b0}}, din.den} << BIT;
        re_ext = {{DEN_W{1'b0}}, din.re_rem};
        im_ext = {{DEN_W{1'b0}}, din.im_rem};
        if (din.op == OP_DIV && !din.dz)
        begin
            if (re_ext >= dsh)
            begin
                work_next.re_rem = NUM_W'(re_ext - dsh);
                work_next.re_quo[BIT] = 1'b1;
            end
            if (im_ext >= dsh)
            begin
                work_next.im_rem = NUM_W'(im_ext - dsh);
                work_next.im_quo[BIT] = 1'b1;
            end
        end
    end

    // Valid is control; the rest of the stage is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= work_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            payload_reg <= work_next[$bits(cau_work_t)-2:0];
    end

    assign dout = cau_work_t'({valid_reg, payload_reg});

endmodule

// File: sv/cau_front.sv
// Operand stage: sums, products, squared divisor magnitude and scaled numerators.
module cau_front
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cau_req_t  req,
    output cau_work_t dout
);

    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] q_rr_reg, q_ii_reg;
    logic signed [16:0] add_re_reg, add_im_reg;
    logic [1:0] op_reg;
    logic       valid_reg;
    logic                         work_valid_reg;
    logic [$bits(cau_work_t)-2:0] work_data_reg;
    cau_work_t  work_next;
    logic signed [PROD_W-1:0] nre, nim;
    logic [NUM_W-1:0] mre, mim;

    // First register: the products and the add/sub results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= req.req_type;
            p_rr_reg <= req.a_real * req.b_real;
            p_ii_reg <= req.a_imag * req.b_imag;
            p_ri_reg <= req.a_real * req.b_imag;
            p_ir_reg <= req.a_imag * req.b_real;
            q_rr_reg <= req.b_real * req.b_real;
            q_ii_reg <= req.b_imag * req.b_imag;
            add_re_reg <= (req.req_type == OP_SUB) ?
                17'(req.a_real) - 17'(req.b_real) : 17'(req.a_real) + 17'(req.b_real);
            add_im_reg <= (req.req_type == OP_SUB) ?
                17'(req.a_imag) - 17'(req.b_imag) : 17'(req.a_imag) + 17'(req.b_imag);
        end
    end

    // Combine the products into a work item for the divider chain.
    always_comb
    begin
        work_next = '0;
        work_next.valid = valid_reg;
        work_next.op = op_reg;
        work_next.den = DEN_W'(q_rr_reg) + DEN_W'(q_ii_reg);
        work_next.dz = (op_reg == OP_DIV) && (work_next.den == '0);
        if (op_reg == OP_MUL)
        begin
            nre = PROD_W'(p_rr_reg) - PROD_W'(p_ii_reg);
            nim = PROD_W'(p_ri_reg) + PROD_W'(p_ir_reg);
            work_next.re_pre = nre >>> FRAC_BITS;
            work_next.im_pre = nim >>> FRAC_BITS;
        end
        else
        begin
            nre = PROD_W'(p_rr_reg) + PROD_W'(p_ii_reg);
            nim = PROD_W'(p_ir_reg) - PROD_W'(p_ri_reg);
            work_next.re_pre = PROD_W'(add_re_reg);
            work_next.im_pre = PROD_W'(add_im_reg);
        end
        work_next.re_neg = nre[PROD_W-1];
        work_next.im_neg = nim[PROD_W-1];
        mre = nre[PROD_W-1] ? NUM_W'(-nre) : NUM_W'(nre);
        mim = nim[PROD_W-1] ? NUM_W'(-nim) : NUM_W'(nim);
        work_next.re_rem = mre << FRAC_BITS;
        work_next.im_rem = mim << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_valid_reg <= 1'b0;
        else if (en)
            work_valid_reg <= work_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_data_reg <= work_next[$bits(cau_work_t)-2:0];
    end

    assign dout = cau_work_t'({work_valid_reg, work_data_reg});

endmodule
